FILE: rtl/core/rrvf_pkg.sv
// Shared types, codes and constants for the range rule value filter.
package rrvf_pkg;

  localparam int VALUE_W       = 64;
  localparam int KIND_W        = 4;
  localparam int HELD_W        = 5;
  localparam int MAX_RULES_DEF = 16;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_TEST   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_EQ = 4'd0;
  localparam logic [KIND_W-1:0] KIND_GT = 4'd1;
  localparam logic [KIND_W-1:0] KIND_GE = 4'd2;
  localparam logic [KIND_W-1:0] KIND_LT = 4'd3;
  localparam logic [KIND_W-1:0] KIND_LE = 4'd4;
  localparam logic [KIND_W-1:0] KIND_OO = 4'd5;
  localparam logic [KIND_W-1:0] KIND_CO = 4'd6;
  localparam logic [KIND_W-1:0] KIND_OC = 4'd7;
  localparam logic [KIND_W-1:0] KIND_CC = 4'd8;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               retain;
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
  } rule_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

endpackage

FILE: rtl/core/rrvf_ram.sv
// Generic single-port-write, registered-read RAM.
module rrvf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/rrvf_eval.sv
// Evaluates one stored rule against a value and flags a retain mismatch.
module rrvf_eval import rrvf_pkg::*; (
  input  rule_t              rule,
  input  logic [VALUE_W-1:0] value,
  output logic               mismatch
);

  logic above_lo, equal_lo, below_hi, equal_hi, hit;

  assign above_lo = value > rule.lo;
  assign equal_lo = value == rule.lo;
  assign below_hi = value < rule.hi;
  assign equal_hi = value == rule.hi;

  always_comb begin
    case (rule.kind)
      KIND_EQ: hit = equal_lo;
      KIND_GT: hit = above_lo;
      KIND_GE: hit = above_lo | equal_lo;
      KIND_LT: hit = below_hi;
      KIND_LE: hit = below_hi | equal_hi;
      KIND_OO: hit = above_lo & below_hi;
      KIND_CO: hit = (above_lo | equal_lo) & below_hi;
      KIND_OC: hit = above_lo & (below_hi | equal_hi);
      KIND_CC: hit = (above_lo | equal_lo) & (below_hi | equal_hi);
      default: hit = 1'b0;
    endcase
  end

  assign mismatch = hit != rule.retain;

endmodule

FILE: rtl/core/range_rule_value_filter.sv
// Top level of the range rule value filter: control sequencer around the rule memory.
//
// A request is taken at a rising edge where start is high and busy is low. The
// mode input selects clear, append or test. Every request gives exactly one
// result: done is high for one cycle with drop, rejected and rules_held valid.
//
// Clear, append and the unused mode finish in one cycle: the result shows in
// the cycle after the request, and busy stays low, so requests of this kind
// may come every cycle. A test walks the stored rules one per cycle through
// the single read port of the rule memory, whose read is registered. The scan
// visits ST_SCAN once per held rule, then ST_DRAIN registers the result onto
// done; busy is high through ST_SCAN and ST_DRAIN and is low again when the
// result shows. With an empty table the result shows in the cycle after the request.
//
// Reset empties the table at once; memory contents are not cleared since an
// entry is only read after it was written. The receiver cannot stall results,
// and a new request may be taken in the same cycle a result is shown.
module range_rule_value_filter import rrvf_pkg::*; #(
  parameter int MAX_RULES = MAX_RULES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [KIND_W-1:0]  rule_kind,
  input  logic               retain,
  input  logic [VALUE_W-1:0] first_number,
  input  logic [VALUE_W-1:0] second_number,
  output logic               done,
  output logic               drop,
  output logic               rejected,
  output logic [HELD_W-1:0]  rules_held
);

  localparam int AW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);

  state_t             state, state_next;
  logic [CNT_W-1:0]   rule_cnt, rule_cnt_next;
  logic [AW-1:0]      idx, idx_next;
  logic               chk, chk_next;
  logic               hit, hit_next;
  logic [VALUE_W-1:0] value_q, value_next;
  logic               done_next, drop_next, rejected_next;

  logic               accept, full, kind_ok, last;
  logic               wr_en, rd_en, mismatch;
  rule_t              wr_rule, rd_rule;

  assign accept  = start && !busy;
  assign full    = rule_cnt == CNT_W'(MAX_RULES);
  assign kind_ok = rule_kind <= KIND_CC;
  assign last    = CNT_W'(idx) == rule_cnt - CNT_W'(1);
  assign wr_en   = accept && mode == MODE_APPEND && kind_ok && !full;
  assign rd_en   = state == ST_SCAN;

  // One-sided upper rules keep their bound in the high field.
  always_comb begin
    wr_rule.kind   = rule_kind;
    wr_rule.retain = retain;
    wr_rule.lo     = first_number;
    wr_rule.hi     = (rule_kind == KIND_LT || rule_kind == KIND_LE) ?
                     first_number : second_number;
  end

  rrvf_ram #(
    .WIDTH ($bits(rule_t)),
    .DEPTH (MAX_RULES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (rule_cnt[AW-1:0]),
    .wdata (wr_rule),
    .re    (rd_en),
    .raddr (idx),
    .rdata (rd_rule)
  );

  rrvf_eval u_eval (
    .rule     (rd_rule),
    .value    (value_q),
    .mismatch (mismatch)
  );

  always_comb begin
    state_next    = state;
    rule_cnt_next = rule_cnt;
    idx_next      = idx;
    chk_next      = 1'b0;
    hit_next      = hit | (chk & mismatch);
    value_next    = value_q;
    done_next     = 1'b0;
    drop_next     = 1'b0;
    rejected_next = 1'b0;
    busy          = state != ST_IDLE;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_CLEAR: begin
              rule_cnt_next = '0;
              done_next     = 1'b1;
            end
            MODE_APPEND: begin
              if (kind_ok && !full) begin
                rule_cnt_next = rule_cnt + CNT_W'(1);
              end
              rejected_next = kind_ok && full;
              done_next     = 1'b1;
            end
            MODE_TEST: begin
              value_next = first_number;
              idx_next   = '0;
              hit_next   = 1'b0;
              if (rule_cnt == '0) begin
                done_next = 1'b1;
              end else begin
                state_next = ST_SCAN;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // The read issued here is checked in the cycle after.
        chk_next = 1'b1;
        if (last) begin
          state_next = ST_DRAIN;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      ST_DRAIN: begin
        done_next  = 1'b1;
        drop_next  = hit | (chk & mismatch);
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rule_cnt <= '0;
      chk      <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      rule_cnt <= rule_cnt_next;
      chk      <= chk_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    hit      <= hit_next;
    value_q  <= value_next;
    drop     <= drop_next;
    rejected <= rejected_next;
  end

  assign rules_held = HELD_W'(rule_cnt);

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    rule_cnt <= CNT_W'(MAX_RULES))
    else $error("rule count exceeds table size");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("request neither finished nor in progress");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("result shown while a test is still running");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    (done && rejected) |-> full)
    else $error("append rejected with room in the table");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the range rule value filter: directed table, then random requests.
module tb_top;
  import rrvf_pkg::*;

  localparam int RULE_CAP = MAX_RULES_DEF;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DIRECTED_ROWS = 25;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam logic [KIND_W-1:0] KIND_FIRST_UNKNOWN = 4'd9;
  localparam logic [KIND_W-1:0] KIND_LAST_UNKNOWN = 4'd15;
  localparam logic [VALUE_W-1:0] TOP = '1;

  typedef struct packed {
    logic              drop;
    logic              rejected;
    logic [HELD_W-1:0] held;
  } outcome_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [KIND_W-1:0]  kind;
    logic               keep;
    logic [VALUE_W-1:0] a_num;
    logic [VALUE_W-1:0] b_num;
    logic               typed;
    outcome_t           want;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         mode;
  logic [KIND_W-1:0]  rule_kind;
  logic               retain;
  logic [VALUE_W-1:0] first_number;
  logic [VALUE_W-1:0] second_number;
  logic               done;
  logic               drop;
  logic               rejected;
  logic [HELD_W-1:0]  rules_held;

  // Shadow copy of the rule table.
  int                 rules_in_table;
  logic [KIND_W-1:0]  kind_tab [RULE_CAP];
  logic               keep_tab [RULE_CAP];
  logic [VALUE_W-1:0] lo_tab [RULE_CAP];
  logic [VALUE_W-1:0] hi_tab [RULE_CAP];

  outcome_t pending_outcomes [$];
  int       mismatches;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{MODE_TEST,   KIND_EQ, 1'b0, TOP,    64'd0, 1'b1, '{1'b0, 1'b0, 5'd0}},
    '{MODE_NOP,    KIND_EQ, 1'b0, 64'd0,  64'd0, 1'b1, '{1'b0, 1'b0, 5'd0}},
    '{MODE_APPEND, KIND_LAST_UNKNOWN, 1'b1, TOP, TOP, 1'b1, '{1'b0, 1'b0, 5'd0}},
    '{MODE_APPEND, KIND_EQ, 1'b0, TOP,    64'd0, 1'b0, '0},
    '{MODE_APPEND, KIND_GT, 1'b1, 64'd0,  TOP,   1'b0, '0},
    '{MODE_APPEND, KIND_GE, 1'b1, 64'd0,  64'd0, 1'b0, '0},
    '{MODE_APPEND, KIND_LT, 1'b1, TOP,    64'd0, 1'b0, '0},
    '{MODE_APPEND, KIND_LE, 1'b1, TOP,    64'd0, 1'b0, '0},
    // Lower bound above upper bound: this rule can never match.
    '{MODE_APPEND, KIND_OO, 1'b0, TOP,    64'd0, 1'b0, '0},
    '{MODE_APPEND, KIND_CO, 1'b1, 64'd0,  TOP,   1'b0, '0},
    '{MODE_APPEND, KIND_OC, 1'b0, TOP,    TOP,   1'b0, '0},
    '{MODE_APPEND, KIND_CC, 1'b1, 64'd0,  TOP,   1'b0, '0},
    '{MODE_TEST,   KIND_EQ, 1'b0, 64'd0,  64'd0, 1'b0, '0},
    '{MODE_TEST,   KIND_CC, 1'b1, TOP,    TOP,   1'b0, '0},
    '{MODE_TEST,   KIND_EQ, 1'b0, 64'd5,  TOP,   1'b0, '0},
    '{MODE_APPEND, KIND_GE, 1'b1, 64'd0,  TOP,   1'b0, '0},
    '{MODE_APPEND, KIND_GE, 1'b1, 64'd0,  TOP,   1'b0, '0},
    '{MODE_APPEND, KIND_GE, 1'b1, 64'd0,  TOP,   1'b0, '0},
    '{MODE_APPEND, KIND_GE, 1'b1, 64'd0,  TOP,   1'b0, '0},
    '{MODE_APPEND, KIND_GE, 1'b1, 64'd0,  TOP,   1'b0, '0},
    '{MODE_APPEND, KIND_GE, 1'b1, 64'd0,  TOP,   1'b0, '0},
    '{MODE_APPEND, KIND_GE, 1'b1, 64'd0,  TOP,   1'b0, '0},
    '{MODE_APPEND, KIND_CC, 1'b1, 64'd0,  TOP,   1'b1, '{1'b0, 1'b1, 5'd16}},
    '{MODE_TEST,   KIND_EQ, 1'b0, 64'd42, 64'd0, 1'b0, '0},
    '{MODE_CLEAR,  KIND_CC, 1'b1, TOP,    TOP,   1'b1, '{1'b0, 1'b0, 5'd0}}
  };

  range_rule_value_filter #(
    .MAX_RULES(RULE_CAP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .rule_kind(rule_kind),
    .retain(retain),
    .first_number(first_number),
    .second_number(second_number),
    .done(done),
    .drop(drop),
    .rejected(rejected),
    .rules_held(rules_held)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic rule_hit(int idx, logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    lo = lo_tab[idx];
    hi = hi_tab[idx];
    case (kind_tab[idx])
      KIND_EQ: return v == lo;
      KIND_GT: return v > lo;
      KIND_GE: return v >= lo;
      KIND_LT: return v < hi;
      KIND_LE: return v <= hi;
      KIND_OO: return v > lo && v < hi;
      KIND_CO: return v >= lo && v < hi;
      KIND_OC: return v > lo && v <= hi;
      KIND_CC: return v >= lo && v <= hi;
      default: return 1'b0;
    endcase
  endfunction

  // Updates the shadow table for one request and returns the result it should give.
  function automatic outcome_t apply_request(logic [1:0] op, logic [KIND_W-1:0] kind,
                                             logic keep, logic [VALUE_W-1:0] a_num,
                                             logic [VALUE_W-1:0] b_num);
    outcome_t res;
    res = '0;
    case (op)
      MODE_CLEAR: rules_in_table = 0;
      MODE_APPEND: begin
        if (kind <= KIND_CC) begin
          if (rules_in_table >= RULE_CAP) begin
            res.rejected = 1'b1;
          end else begin
            kind_tab[rules_in_table] = kind;
            keep_tab[rules_in_table] = keep;
            if (kind == KIND_LT || kind == KIND_LE) begin
              lo_tab[rules_in_table] = '0;
              hi_tab[rules_in_table] = a_num;
            end else if (kind <= KIND_GE) begin
              lo_tab[rules_in_table] = a_num;
              hi_tab[rules_in_table] = '0;
            end else begin
              lo_tab[rules_in_table] = a_num;
              hi_tab[rules_in_table] = b_num;
            end
            rules_in_table++;
          end
        end
      end
      MODE_TEST: begin
        for (int i = 0; i < rules_in_table; i++) begin
          if (rule_hit(i, a_num) != keep_tab[i]) begin
            res.drop = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    res.held = HELD_W'(rules_in_table);
    return res;
  endfunction

  // Favors extremes and values right next to bounds already in the table.
  function automatic logic [VALUE_W-1:0] pick_value();
    int idx;
    logic [VALUE_W-1:0] base;
    case ($urandom_range(0, 6))
      0: return '0;
      1: return TOP;
      2: return VALUE_W'($urandom_range(0, 20));
      3: return TOP - VALUE_W'($urandom_range(0, 20));
      4, 5: begin
        if (rules_in_table == 0) return {$urandom, $urandom};
        idx = $urandom_range(0, rules_in_table - 1);
        base = $urandom_range(0, 1) ? lo_tab[idx] : hi_tab[idx];
        return base + VALUE_W'($urandom_range(0, 2)) - VALUE_W'(1);
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic pause();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 55) n = 0;
    else if (pick < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start = 1'b0;
      mode = 2'($urandom);
      rule_kind = KIND_W'($urandom);
      retain = 1'($urandom);
      first_number = {$urandom, $urandom};
      second_number = {$urandom, $urandom};
      repeat (n) @(negedge clk);
    end
  endtask

  // Holds one request until the block takes it, then records what it should return.
  task automatic issue(logic [1:0] op, logic [KIND_W-1:0] kind, logic keep,
                       logic [VALUE_W-1:0] a_num, logic [VALUE_W-1:0] b_num,
                       logic typed, outcome_t want);
    outcome_t calc;
    mode = op;
    rule_kind = kind;
    retain = keep;
    first_number = a_num;
    second_number = b_num;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    calc = apply_request(op, kind, keep, a_num, b_num);
    if (typed) calc = want;
    pending_outcomes.insert(pending_outcomes.size(), calc);
    @(negedge clk);
    pause();
  endtask

  always @(posedge clk) begin : check_result
    outcome_t head;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result: expected none, got drop=%0d rejected=%0d held=%0d",
                 $time, drop, rejected, rules_held);
        mismatches++;
      end else begin
        head = pending_outcomes.pop_front();
        if (drop !== head.drop) begin
          $display("%0t: drop: expected %0d, got %0d", $time, head.drop, drop);
          mismatches++;
        end
        if (rejected !== head.rejected) begin
          $display("%0t: rejected: expected %0d, got %0d", $time, head.rejected, rejected);
          mismatches++;
        end
        if (rules_held !== head.held) begin
          $display("%0t: rules_held: expected %0d, got %0d", $time, head.held, rules_held);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int served;
    int pick;
    int n_rules;
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_CLEAR;
    rule_kind = KIND_EQ;
    retain = 1'b0;
    first_number = '0;
    second_number = '0;
    mismatches = 0;
    rules_in_table = 0;
    served = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      issue(directed_rows[k].op, directed_rows[k].kind, directed_rows[k].keep,
            directed_rows[k].a_num, directed_rows[k].b_num,
            directed_rows[k].typed, directed_rows[k].want);
    end

    // Random part: mostly a clear, a burst of appends, then a few tests on that table.
    while (served < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        issue(MODE_NOP, KIND_W'($urandom), 1'($urandom), {$urandom, $urandom},
              {$urandom, $urandom}, 1'b0, '0);
        served++;
      end else if (pick < 10) begin
        issue(MODE_APPEND, KIND_W'($urandom_range(KIND_FIRST_UNKNOWN, KIND_LAST_UNKNOWN)),
              1'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, '0);
        served++;
      end else begin
        if ($urandom_range(0, 9) < 8) begin
          issue(MODE_CLEAR, KIND_W'($urandom), 1'($urandom), {$urandom, $urandom},
                {$urandom, $urandom}, 1'b0, '0);
          served++;
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) n_rules = $urandom_range(1, 4);
        else if (pick < 9) n_rules = $urandom_range(5, 15);
        else n_rules = $urandom_range(16, 18);
        repeat (n_rules) begin
          issue(MODE_APPEND, KIND_W'($urandom_range(KIND_EQ, KIND_CC)), 1'($urandom),
                pick_value(), pick_value(), 1'b0, '0);
          served++;
        end
        repeat ($urandom_range(1, 6)) begin
          issue(MODE_TEST, KIND_W'($urandom), 1'($urandom), pick_value(),
                {$urandom, $urandom}, 1'b0, '0);
          served++;
        end
      end
    end

    start = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (RULE_CAP + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
